### rtl/core/rsh_pkg.sv
// Shared types and constants of the RGB 3x3 sharpen filter.
// Used by the channel lanes and the top level; depends on nothing.
package rsh_pkg;

    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [FW_W-1:0]  FW_RESET = 11'd640;
    localparam logic [FH_W-1:0]  FH_RESET = 12'd480;
    localparam logic [ROW_W-1:0] ROW_MAX  = 12'd4095;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // Which neighbors of the center lie inside the frame.
    typedef struct packed {
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
    } rsh_mask_t;

    typedef struct packed {
        logic      emit;
        logic      last;
        rsh_mask_t mask;
    } rsh_meta_t;

endpackage

### rtl/core/rsh_line_buffer.sv
// Simple dual-port line buffer memory with registered read and write forwarding.
// Holds both line stores side by side in one word; depends on nothing.
module rsh_line_buffer #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            // A write to the same entry in this cycle must be seen by the read.
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/rsh_lane.sv
// One color channel of the sharpen kernel: 9 * center minus the in-frame neighbors,
// then absolute value and saturation. Depends on rsh_pkg for the neighbor mask.
module rsh_lane #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic [8:0][CHANNEL_BITS-1:0] taps,
    input  rsh_pkg::rsh_mask_t           mask,
    output logic [CHANNEL_BITS-1:0]      magnitude
);

    import rsh_pkg::*;

    localparam int CB     = CHANNEL_BITS;
    localparam int SUM_W  = CB + 5;
    localparam int CH_MAX = (1 << CB) - 1;

    logic [8:0]              use_tap;
    logic [CB+2:0]           neg_sum;
    logic [CB+3:0]           pos_sum;
    logic signed [SUM_W-1:0] diff;
    logic [SUM_W-1:0]        mag;

    always_comb
    begin
        use_tap = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                use_tap[r*3+c] = !((r == 0) && !mask.top_ok) &&
                                 !((r == 2) && !mask.bottom_ok) &&
                                 !((c == 0) && !mask.left_ok) &&
                                 !((c == 2) && !mask.right_ok) &&
                                 !((r == 1) && (c == 1));
            end
        end

        neg_sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (use_tap[i])
            begin
                neg_sum = neg_sum + (CB+3)'(taps[i]);
            end
        end

        pos_sum = (CB+4)'({taps[4], 3'b000}) + (CB+4)'(taps[4]);
        diff    = signed'(SUM_W'(pos_sum)) - signed'(SUM_W'(neg_sum));
        mag     = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);

        if (mag > SUM_W'(CH_MAX))
        begin
            magnitude = '1;
        end
        else
        begin
            magnitude = mag[CB-1:0];
        end
    end

endmodule

### rtl/core/rgb_sharpen_3x3_filter.sv
// Top level of the streaming RGB 3x3 sharpen filter: position tracking, window,
// three channel lanes and the output register. Uses rsh_pkg, rsh_line_buffer, rsh_lane.
//
//  channel   signals                                        width     direction
//  -------   --------------------------------------------   -------   ---------
//  config    cfg_write_en, cfg_index, cfg_data              1/1/12    in
//  input     in_valid, in_ready, operation, in_red/green/blue  3*CB+1 in
//  output    out_valid, out_ready, out_red/green/blue, out_last 3*CB+1 out
//
// One input beat is taken every clock while in_ready is high; the line buffer is read and
// written once per beat, which sets that rate. A result passes stage one, the window and
// the output register; a frame of W x H pixels needs W*H + W + 1 input beats.
// Reset clears positions, window, pipeline valids and restores width 640, height 480;
// the line buffer memory is not cleared. While a result waits at the output, input
// beats are still taken as long as a pipeline stage ahead of it is free.
module rgb_sharpen_3x3_filter #(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [rsh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rsh_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic [CHANNEL_BITS-1:0]         in_red,
    input  logic [CHANNEL_BITS-1:0]         in_green,
    input  logic [CHANNEL_BITS-1:0]         in_blue,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [CHANNEL_BITS-1:0]         out_red,
    output logic [CHANNEL_BITS-1:0]         out_green,
    output logic [CHANNEL_BITS-1:0]         out_blue,
    output logic                            out_last
);

    import rsh_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int PX_W  = 3 * CHANNEL_BITS;
    localparam int COL_W = $clog2(MAX_WIDTH);
    // Wide enough for the width register and for MAX_WIDTH itself.
    localparam int EW_W  = ($clog2(MAX_WIDTH) + 1 > FW_W) ? $clog2(MAX_WIDTH) + 1 : FW_W;

    // Configuration registers.
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;

    // Frame positions.
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;

    // Stage one: beat waiting for its line buffer data.
    logic             s1_valid_reg;
    logic [PX_W-1:0]  s1_px_reg;
    logic [COL_W-1:0] s1_addr_reg;
    rsh_meta_t        s1_meta_reg;

    // Stage two: the window holds a complete neighborhood for one result.
    logic                 s2_valid_reg;
    rsh_meta_t            s2_meta_reg;
    logic [8:0][PX_W-1:0] window_reg;

    // Output register.
    logic          out_valid_reg;
    logic [CB-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic          out_last_reg;

    logic accept, s1_adv, s2_adv;

    logic [EW_W-1:0]  fw_ext, eff_w, in_col_inc, out_col_inc;
    logic [FH_W-1:0]  eff_h;
    logic [FH_W:0]    out_row_inc;
    logic [COL_W-1:0] in_col, out_col;
    logic             in_col_end, out_col_end, out_row_end;
    logic [PX_W-1:0]  in_px;
    rsh_meta_t        meta;

    logic [2*PX_W-1:0] lb_rd_data;
    logic [2*PX_W-1:0] lb_wr_data;
    logic [PX_W-1:0]   lb_top, lb_mid;

    logic [2:0][CB-1:0] lane_mag;

    // Handshake: each stage moves when the stage after it is empty or moving too.
    assign s2_adv   = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // Effective frame size, position wrap and next positions for the beat at the input.
    always_comb
    begin
        fw_ext = EW_W'(frame_width_reg);
        priority if (fw_ext == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (fw_ext > EW_W'(MAX_WIDTH))
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
        eff_h = (frame_height_reg == '0) ? FH_W'(1) : frame_height_reg;

        // Positions left beyond a smaller width wrap to the row start.
        in_col  = (EW_W'(in_col_reg) >= eff_w) ? '0 : in_col_reg;
        out_col = (EW_W'(out_col_reg) >= eff_w) ? '0 : out_col_reg;

        in_col_inc  = EW_W'(in_col) + EW_W'(1);
        in_col_end  = in_col_inc >= eff_w;
        out_col_inc = EW_W'(out_col) + EW_W'(1);
        out_col_end = out_col_inc >= eff_w;
        out_row_inc = (FH_W+1)'(out_row_reg) + (FH_W+1)'(1);
        out_row_end = out_row_inc >= (FH_W+1)'(eff_h);

        meta.emit           = (in_row_reg >= ROW_W'(2)) ||
                              ((in_row_reg == ROW_W'(1)) && (in_col != '0));
        meta.last           = out_row_end && out_col_end;
        meta.mask.top_ok    = out_row_reg != '0;
        meta.mask.bottom_ok = !out_row_end;
        meta.mask.left_ok   = out_col != '0;
        meta.mask.right_ok  = !out_col_end;

        // A flush beat inside the frame counts as a black pixel.
        in_px = (operation == OP_FLUSH) ? '0 : {in_blue, in_green, in_red};

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (accept)
        begin
            in_col_next  = in_col_end ? '0 : COL_W'(in_col_inc);
            in_row_next  = (in_col_end && (in_row_reg != ROW_MAX)) ?
                           in_row_reg + ROW_W'(1) : in_row_reg;
            out_col_next = out_col;
            if (meta.emit)
            begin
                priority if (meta.last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_end)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ROW_W'(1);
                end
                else
                begin
                    out_col_next = COL_W'(out_col_inc);
                end
            end
        end
    end

    // Line buffer word: upper store in the high half, lower store in the low half.
    // Reading a column gives rows r-2 and r-1; the write shifts them up by one row.
    assign lb_top     = lb_rd_data[2*PX_W-1:PX_W];
    assign lb_mid     = lb_rd_data[PX_W-1:0];
    assign lb_wr_data = {lb_mid, s1_px_reg};

    rsh_line_buffer #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PX_W)
    ) u_line_buffer (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_col),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (lb_wr_data),
        .rd_data (lb_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            window_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                endcase
            end

            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Every beat shifts the window; only emitting beats leave a result behind.
            if (s1_adv)
            begin
                s2_valid_reg  <= s1_meta_reg.emit;
                window_reg[0] <= window_reg[1];
                window_reg[1] <= window_reg[2];
                window_reg[2] <= lb_top;
                window_reg[3] <= window_reg[4];
                window_reg[4] <= window_reg[5];
                window_reg[5] <= lb_mid;
                window_reg[6] <= window_reg[7];
                window_reg[7] <= window_reg[8];
                window_reg[8] <= s1_px_reg;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= in_px;
            s1_addr_reg <= in_col;
            s1_meta_reg <= meta;
        end
        if (s1_adv)
        begin
            s2_meta_reg <= s1_meta_reg;
        end
        if (s2_adv)
        begin
            out_red_reg   <= lane_mag[0];
            out_green_reg <= lane_mag[1];
            out_blue_reg  <= lane_mag[2];
            out_last_reg  <= s2_meta_reg.last;
        end
    end

    // One lane per color channel, all working on the same window.
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [8:0][CB-1:0] taps;

        always_comb
        begin
            for (int i = 0; i < 9; i++)
            begin
                taps[i] = window_reg[i][k*CB +: CB];
            end
        end

        rsh_lane #(
            .CHANNEL_BITS (CHANNEL_BITS)
        ) u_lane (
            .taps      (taps),
            .mask      (s2_meta_reg.mask),
            .magnitude (lane_mag[k])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_last  = out_last_reg;

endmodule
